@@ rtl/core/gac_pkg.sv @@
// Package for the ancestor counting engine: sizes, operation codes and the
// command and status structs shared by the controller and the datapath.
package gac_pkg;
  localparam int NODES = 256;
  localparam int NODE_W = $clog2(NODES);
  localparam int COL_WORDS = (NODES + 63) / 64;
  localparam int WSEL_W = (COL_WORDS > 1) ? $clog2(COL_WORDS) : 1;
  localparam int ADDR_W = $clog2(NODES * COL_WORDS);
  localparam int CNT_W = NODE_W + 1;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  typedef struct packed {
    logic clear_step;
    logic edge_read;
    logic edge_write;
    logic query_init;
    logic pop;
    logic word_read;
    logic word_scan;
    logic next_word;
  } gac_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic stack_empty;
    logic last_word;
    logic scan_done;
  } gac_status_t;
endpackage

@@ rtl/core/gac_ctrl.sv @@
// Controller state machine of the ancestor counting engine.
// Depends on gac_pkg for the command and status structs.
module gac_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  input  logic [1:0]           operation,
  input  logic                 edge_ok,
  input  logic                 start_ok,
  input  logic                 out_busy,
  input  gac_pkg::gac_status_t status,
  output gac_pkg::gac_cmd_t    cmd,
  output logic                 idle,
  output logic                 result_load
);
  import gac_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POP = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  localparam logic [2:0] S_EDGE = 3'd5;
  localparam logic [2:0] S_CLEAR = 3'd6;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  assign idle = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    result_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (operation == OP_ADD && edge_ok) begin
            cmd.edge_read = 1'b1;
            state_next = S_EDGE;
          end
          if (operation == OP_CLEAR) state_next = S_CLEAR;
          if (operation == OP_QUERY) begin
            cmd.query_init = 1'b1;
            state_next = start_ok ? S_POP : S_DONE;
          end
        end
      end
      S_EDGE: begin
        cmd.edge_write = 1'b1;
        state_next = S_IDLE;
      end
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) state_next = S_IDLE;
      end
      S_POP: begin
        if (status.stack_empty) state_next = S_DONE;
        else begin
          cmd.pop = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.word_read = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.word_scan = 1'b1;
        if (status.scan_done) begin
          if (status.last_word) state_next = S_POP;
          else begin
            cmd.next_word = 1'b1;
            state_next = S_READ;
          end
        end
      end
      S_DONE: begin
        if (!out_busy) begin
          result_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTH
  a_done_needs_room: assert property (@(posedge clk) disable iff (rst)
    result_load |-> !out_busy) else $error("result loaded over a pending one");
  a_read_then_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.word_read |=> cmd.word_scan) else $error("read not followed by scan");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !status.stack_empty) else $error("pop of empty stack");
  a_edge_pair: assert property (@(posedge clk) disable iff (rst)
    cmd.edge_read |=> cmd.edge_write) else $error("edge read not followed by write");
`endif
endmodule

@@ rtl/core/gac_datapath.sv @@
// Datapath of the ancestor counting engine: adjacency memory with its clearing
// pass, discovered bits, work stack memory and the per-word bit scanner.
// Depends on gac_pkg for sizes and the command and status structs.
module gac_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  gac_pkg::gac_cmd_t     cmd,
  input  logic [7:0]            column_node,
  input  logic [7:0]            row_node,
  output gac_pkg::gac_status_t  status,
  output logic [7:0]            count
);
  import gac_pkg::*;

  logic [63:0]        adj_mem [NODES*COL_WORDS];
  logic [NODE_W-1:0]  stack_mem [NODES];
  logic [ADDR_W-1:0]  clr_idx;
  logic               clear_last;
  logic [NODES-1:0]   discovered;
  logic [CNT_W-1:0]   depth;
  logic [CNT_W-1:0]   reached;
  logic [NODE_W-1:0]  cur_node;
  logic [WSEL_W-1:0]  wsel;
  logic [63:0]        rd_data;
  logic [63:0]        pending;
  logic [63:0]        cand;
  logic [5:0]         low_bit;
  logic               found;
  logic [NODE_W-1:0]  found_node;
  logic [ADDR_W-1:0]  wr_addr, rd_addr, edge_addr;
  logic [5:0]         edge_bit;
  logic [NODE_W-1:0]  in_col, in_row;

  assign in_col = column_node[NODE_W-1:0];
  assign in_row = row_node[NODE_W-1:0];

  function automatic logic [ADDR_W-1:0] addr_of(logic [NODE_W-1:0] n,
                                                logic [WSEL_W-1:0] w);
    logic [ADDR_W+WSEL_W:0] a;
    a = (ADDR_W+WSEL_W+1)'(n) * (ADDR_W+WSEL_W+1)'(COL_WORDS)
        + (ADDR_W+WSEL_W+1)'(w);
    return a[ADDR_W-1:0];
  endfunction

  assign wr_addr = addr_of(in_col, WSEL_W'(in_row >> 6));
  assign rd_addr = addr_of(cur_node, wsel);

  // An edge is added by reading its word and writing it back with the new bit
  // in the next cycle.
  always_ff @(posedge clk) begin
    if (cmd.clear_step) adj_mem[clr_idx] <= '0;
    else if (cmd.edge_write) adj_mem[edge_addr] <= rd_data | (64'd1 << edge_bit);
    if (cmd.word_read) rd_data <= adj_mem[rd_addr];
    else if (cmd.edge_read) rd_data <= adj_mem[wr_addr];
    if (cmd.edge_read) begin
      edge_addr <= wr_addr;
      edge_bit <= in_row[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) clr_idx <= '0;
    else if (cmd.clear_step) clr_idx <= clear_last ? '0 : clr_idx + 1'b1;
  end

  assign clear_last = (clr_idx == ADDR_W'(NODES * COL_WORDS - 1));

  always_ff @(posedge clk) begin
    if (cmd.query_init) stack_mem[0] <= in_col;
    else if (found && cmd.word_scan) stack_mem[depth[NODE_W-1:0]] <= found_node;
    if (cmd.pop) cur_node <= stack_mem[NODE_W'(depth - 1'b1)];
  end

  always_comb begin
    logic [NODE_W+6:0] bit_idx;
    cand = 64'd0;
    bit_idx = '0;
    for (int i = 0; i < 64; i++) begin
      bit_idx = (NODE_W+7)'(wsel) * (NODE_W+7)'(64) + (NODE_W+7)'(i);
      if (bit_idx < (NODE_W+7)'(NODES))
        cand[i] = rd_data[i] && !discovered[bit_idx[NODE_W-1:0]];
    end
  end

  logic [63:0] scan_bits;
  logic        first_scan;
  assign scan_bits = first_scan ? cand : pending;

  always_comb begin
    low_bit = '0;
    found = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (scan_bits[i]) begin
        low_bit = 6'(i);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    logic [NODE_W+6:0] n;
    n = (NODE_W+7)'(wsel) * (NODE_W+7)'(64) + (NODE_W+7)'(low_bit);
    found_node = n[NODE_W-1:0];
  end

  assign status.scan_done = !found ||
    ((scan_bits & ~(64'd1 << low_bit)) == 64'd0);
  assign status.last_word = (wsel == WSEL_W'(COL_WORDS - 1));
  assign status.stack_empty = (depth == '0);
  assign status.clear_last = clear_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      discovered <= '0;
      depth <= '0;
      reached <= '0;
      first_scan <= 1'b0;
      wsel <= '0;
    end else begin
      if (cmd.query_init) begin
        discovered <= '0;
        discovered[in_col] <= 1'b1;
        depth <= CNT_W'(1);
        reached <= '0;
        wsel <= '0;
      end
      if (cmd.pop) begin
        depth <= depth - 1'b1;
        wsel <= '0;
      end
      if (cmd.word_read) first_scan <= 1'b1;
      if (cmd.word_scan) begin
        first_scan <= 1'b0;
        pending <= scan_bits & ~(64'd1 << low_bit);
        if (found) begin
          discovered[found_node] <= 1'b1;
          reached <= reached + 1'b1;
          depth <= depth + 1'b1;
        end
      end
      if (cmd.next_word) wsel <= wsel + 1'b1;
    end
  end

  assign count = (reached > CNT_W'(255)) ? 8'd255 : 8'(reached);

`ifndef SYNTH
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= CNT_W'(NODES)) else $error("stack overflow");
  a_reach_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.word_scan && found) |=> reached == $past(reached) + 1'b1)
    else $error("count did not advance");
  a_start_marked: assert property (@(posedge clk) disable iff (rst)
    cmd.query_init |=> discovered[$past(in_col)]) else $error("start unmarked");
`endif
endmodule

@@ rtl/core/graph_ancestor_count.sv @@
// Ancestor counting engine: holds a directed graph as an adjacency bitmap and
// answers reachability count queries. After reset the adjacency memory is
// cleared by a pass over all NODES * COL_WORDS (1024) words with s_tready low;
// a clear transfer runs the same pass once it is accepted. An add edge is a
// read and a write of one adjacency word. A query's run time, plus any wait
// for the output register, is set by the single read port of the adjacency
// memory and one new node found per scan cycle.
module graph_ancestor_count (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // operation[1:0], column_node[9:2], row_node[17:10]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata   // ancestor_count[7:0]
);
  import gac_pkg::*;

  gac_cmd_t    cmd;
  gac_status_t status;
  logic        idle, result_load, in_fire, edge_ok, start_ok;
  logic [1:0]  operation;
  logic [7:0]  column_node, row_node, count;

  assign operation = s_tdata[1:0];
  assign column_node = s_tdata[9:2];
  assign row_node = s_tdata[17:10];
  assign s_tready = idle;
  assign in_fire = s_tvalid && s_tready;
  assign edge_ok = (int'(column_node) < NODES) && (int'(row_node) < NODES);
  assign start_ok = int'(column_node) < NODES;

  gac_ctrl u_ctrl (
    .clk, .rst, .in_fire, .operation, .edge_ok, .start_ok,
    .out_busy(m_tvalid && !m_tready), .status, .cmd, .idle, .result_load
  );

  gac_datapath u_dp (
    .clk, .rst, .cmd, .column_node, .row_node, .status, .count
  );

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (result_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) if (result_load) m_tdata <= count;
endmodule
